// ----- sv/bvg_pkg.sv -----
`default_nettype none
package bvg_pkg;

  // Field widths
  localparam int ADC_W      = 12;
  localparam int RATIO_W    = 10;
  localparam int LOWMV_W    = 15;
  localparam int MV_W       = 16;
  localparam int PCT_W      = 7;

  // Samples per averaging group (power of two)
  localparam int GROUP_SAMPLES = 8;
  localparam int SUM_W = ADC_W + $clog2(GROUP_SAMPLES);
  localparam int CNT_W = (GROUP_SAMPLES > 1) ? $clog2(GROUP_SAMPLES) : 1;

  // Config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_RATIO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_BATTERY   = 2'd1;
  localparam logic [RATIO_W-1:0] RATIO_RESET  = 10'd200;
  localparam logic [LOWMV_W-1:0] LOWMV_RESET  = 15'd3300;

  // Queue between accumulator and scaling sequencer
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // One group average travelling through the queue
  typedef struct packed {
    logic             valid;
    logic [ADC_W-1:0] avg;
  } bvg_avg_t;

endpackage
`default_nettype wire

// ----- sv/battery_voltage_gauge_unit.sv -----
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_stall   | adc_sample[11:0], sample_valid
// out_    | output    | out_valid / out_stall | average_raw, battery_mv, battery_low,
//         |           |                       | charge_percent
// cfg_    | input     | cfg_valid / cfg_ready | cfg_index[1:0], cfg_data[14:0]
//
// Samples are taken one per cycle by the accumulator while in_stall is low; every
// eighth sample pushes a group average into a two-entry queue.
// Per group the scaling sequencer runs two reciprocal multiply and correct
// divisions plus the curve step, and keeps up with one result every 8 samples.
// Reset (rst_n low, synchronous) clears the sum, count, queue and output valid and
// loads the register defaults. in_stall rises only while the queue is full;
// out_stall holds the result register and the sequencer waits behind it.
`default_nettype none
module battery_voltage_gauge_unit
  import bvg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [ADC_W-1:0]      in_adc_sample,
  input  wire logic                  in_sample_valid,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [ADC_W-1:0]           out_average_raw,
  output logic [MV_W-1:0]            out_battery_mv,
  output logic                       out_battery_low,
  output logic [PCT_W-1:0]           out_charge_percent,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [RATIO_W-1:0] ratio_r;
  logic [LOWMV_W-1:0] low_mv_r;
  bvg_avg_t           push;
  bvg_avg_t           head;
  logic               q_full;
  logic               pop;

  // Config registers; writes outside the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r  <= RATIO_RESET;
      low_mv_r <= LOWMV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DIVIDER_RATIO: ratio_r  <= cfg_data[RATIO_W-1:0];
        REG_LOW_BATTERY:   low_mv_r <= cfg_data[LOWMV_W-1:0];
        default: ;
      endcase
    end
  end

  bvg_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_adc_sample   (in_adc_sample),
    .in_sample_valid (in_sample_valid),
    .q_full          (q_full),
    .push            (push)
  );

  bvg_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  bvg_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .pop                (pop),
    .ratio              (ratio_r),
    .low_mv             (low_mv_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_average_raw    (out_average_raw),
    .out_battery_mv     (out_battery_mv),
    .out_battery_low    (out_battery_low),
    .out_charge_percent (out_charge_percent)
  );

`ifndef NO_ASSERTIONS
  // Queue never takes a push while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push.valid)
    else $error("group average pushed into a full queue");

  // Percent stays on the curve range
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_charge_percent <= PCT_W'(100)))
    else $error("charge percent above 100");

  // Low flag agrees with the reported voltage and the threshold
  a_low_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_battery_low == (out_battery_mv < MV_W'(low_mv_r))))
    else $error("low flag disagrees with battery voltage");

  // Zero average gives zero voltage and zero charge
  a_zero_avg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_average_raw == '0) |->
      (out_battery_mv == '0 && out_charge_percent == '0))
    else $error("nonzero voltage from a zero average");
`endif

endmodule
`default_nettype wire

// ----- sv/bvg_front.sv -----
`default_nettype none
module bvg_front
  import bvg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [ADC_W-1:0] in_adc_sample,
  input  wire logic             in_sample_valid,
  input  wire logic             q_full,
  output bvg_avg_t              push
);

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum_acc;
  logic             accept;
  logic             last;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign last     = (cnt_r == CNT_W'(GROUP_SAMPLES - 1));

  // Failed reads add zero but still count
  assign sum_acc = sum_r + (in_sample_valid ? SUM_W'(in_adc_sample) : SUM_W'(0));

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      if (last) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_acc;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Group complete: hand the average to the queue
  assign push.valid = accept && last;
  assign push.avg   = ADC_W'(sum_acc / GROUP_SAMPLES);

endmodule
`default_nettype wire

// ----- sv/bvg_queue.sv -----
`default_nettype none
module bvg_queue
  import bvg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire bvg_avg_t push,
  output logic          full,
  output bvg_avg_t      head,
  input  wire logic     pop
);

  logic [ADC_W-1:0]  entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.avg   = entry_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.valid && !do_pop) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (!push.valid && do_pop) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  // Pointers wrap at the depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push.valid) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) entry_r[wr_ptr_r] <= push.avg;
  end

endmodule
`default_nettype wire

// ----- sv/bvg_back.sv -----
`default_nettype none
module bvg_back
  import bvg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bvg_avg_t           head,
  output logic                    pop,
  input  wire logic [RATIO_W-1:0] ratio,
  input  wire logic [LOWMV_W-1:0] low_mv,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [ADC_W-1:0]        out_average_raw,
  output logic [MV_W-1:0]         out_battery_mv,
  output logic                    out_battery_low,
  output logic [PCT_W-1:0]        out_charge_percent
);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RCP1  = 3'd1;
  localparam logic [2:0] S_FIX1  = 3'd2;
  localparam logic [2:0] S_MUL2  = 3'd3;
  localparam logic [2:0] S_RCP2  = 3'd4;
  localparam logic [2:0] S_FIX2  = 3'd5;
  localparam logic [2:0] S_CURVE = 3'd6;
  localparam logic [2:0] S_PCT   = 3'd7;

  // Reciprocals: 2^24/4095 rounded down, 2^29/100 rounded down,
  // 2^21/200 and 2^21/300 rounded up (exact for the curve range)
  localparam logic [12:0] RCP_4095 = 13'd4097;
  localparam logic [22:0] RCP_100  = 23'd5368709;
  localparam logic [13:0] RCP_200  = 14'd10486;
  localparam logic [13:0] RCP_300  = 14'd6991;

  localparam logic [11:0] FULL_MV  = 12'd3300;
  localparam logic [11:0] FULL_CODE = 12'd4095;
  localparam logic [6:0]  HUNDRED  = 7'd100;

  localparam logic [MV_W-1:0] KNEE_4200 = 16'd4200;
  localparam logic [MV_W-1:0] KNEE_3900 = 16'd3900;
  localparam logic [MV_W-1:0] KNEE_3700 = 16'd3700;
  localparam logic [MV_W-1:0] KNEE_3500 = 16'd3500;
  localparam logic [MV_W-1:0] KNEE_3300 = 16'd3300;

  logic [2:0]       state_r;
  logic [ADC_W-1:0] avg_r;
  logic [23:0]      p1_r;
  logic [11:0]      q1_r;
  logic [11:0]      adc_mv_r;
  logic [21:0]      p2_r;
  logic [MV_W-1:0]  q2_r;
  logic [MV_W-1:0]  bat_r;
  logic             low_r;
  logic [PCT_W-1:0] off_r;
  logic [12:0]      t_r;
  logic             sel300_r;

  logic             out_free;
  logic [36:0]      rcp1_prod;
  logic [23:0]      rem1;
  logic [44:0]      rcp2_prod;
  logic [21:0]      rem2;
  logic [MV_W-1:0]  seg_base;
  logic [PCT_W-1:0] seg_off;
  logic             seg_sel300;
  logic             seg_flat;
  logic [MV_W-1:0]  diff;
  logic [26:0]      pct_prod;
  logic [PCT_W-1:0] pct_val;

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state_r == S_IDLE) && head.valid;

  assign rcp1_prod = 37'(p1_r) * 37'(RCP_4095);
  assign rem1      = p1_r - 24'(q1_r) * 24'(FULL_CODE);
  assign rcp2_prod = 45'(p2_r) * 45'(RCP_100);
  assign rem2      = p2_r - 22'(q2_r) * 22'(HUNDRED);

  // Pick the curve segment
  always_comb begin
    seg_base   = KNEE_3300;
    seg_off    = 7'd0;
    seg_sel300 = 1'b0;
    seg_flat   = 1'b0;
    if (bat_r >= KNEE_4200) begin
      seg_off  = 7'd100;
      seg_flat = 1'b1;
    end else if (bat_r >= KNEE_3900) begin
      seg_base   = KNEE_3900;
      seg_off    = 7'd75;
      seg_sel300 = 1'b1;
    end else if (bat_r >= KNEE_3700) begin
      seg_base = KNEE_3700;
      seg_off  = 7'd50;
    end else if (bat_r >= KNEE_3500) begin
      seg_base = KNEE_3500;
      seg_off  = 7'd25;
    end else if (bat_r < KNEE_3300) begin
      seg_flat = 1'b1;
    end
  end

  // Quotient of the 2^21-scaled reciprocal sits at bit 21 and up
  assign diff     = bat_r - seg_base;
  assign pct_prod = 27'(t_r) * 27'(sel300_r ? RCP_300 : RCP_200);
  assign pct_val  = off_r + PCT_W'(pct_prod[26:21]);

  // Datapath steps
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        avg_r <= head.avg;
        p1_r  <= 24'(head.avg) * 24'(FULL_MV);
      end
      S_RCP1: q1_r <= rcp1_prod[35:24];
      S_FIX1: adc_mv_r <= (rem1 >= 24'(FULL_CODE)) ? q1_r + 12'd1 : q1_r;
      S_MUL2: p2_r <= 22'(adc_mv_r) * 22'(ratio);
      S_RCP2: q2_r <= rcp2_prod[44:29];
      S_FIX2: bat_r <= (rem2 >= 22'(HUNDRED)) ? q2_r + 16'd1 : q2_r;
      S_CURVE: begin
        low_r    <= (bat_r < MV_W'(low_mv));
        off_r    <= seg_off;
        sel300_r <= seg_sel300;
        t_r      <= seg_flat ? 13'd0 : 13'(diff) * 13'd25;
      end
      default: ;
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state_r == S_PCT && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state_r)
        S_IDLE:  if (head.valid) state_r <= S_RCP1;
        S_RCP1:  state_r <= S_FIX1;
        S_FIX1:  state_r <= S_MUL2;
        S_MUL2:  state_r <= S_RCP2;
        S_RCP2:  state_r <= S_FIX2;
        S_FIX2:  state_r <= S_CURVE;
        S_CURVE: state_r <= S_PCT;
        S_PCT:   if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PCT && out_free) begin
      out_average_raw    <= avg_r;
      out_battery_mv     <= bat_r;
      out_battery_low    <= low_r;
      out_charge_percent <= pct_val;
    end
  end

endmodule
`default_nettype wire
